### design/macs_pkg.sv
// Package with the shared types and sizes of the moving average crossover unit.
`timescale 1ns / 1ps

package macs_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int PRICE_BITS   = 32;
    localparam int PERIOD_BITS  = 8;
    localparam int PTR_BITS     = $clog2(WINDOW_DEPTH);
    localparam int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_BITS     = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
    localparam int SUM_BITS     = PRICE_BITS + PERIOD_BITS;
    localparam int QUOTE_BITS   = 2 * PRICE_BITS;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_IDX_BITS   = $clog2(FIFO_DEPTH);
    localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [PRICE_BITS-1:0]      t_price;
    typedef logic [PERIOD_BITS-1:0]     t_period;
    typedef logic [PTR_BITS-1:0]        t_ptr;
    typedef logic [COUNT_BITS-1:0]      t_count;
    typedef logic [CMP_BITS-1:0]        t_cmp;
    typedef logic [SUM_BITS-1:0]        t_sum;
    typedef logic [QUOTE_BITS-1:0]      t_quote;
    typedef logic [FIFO_IDX_BITS-1:0]   t_fifo_idx;
    typedef logic [FIFO_COUNT_BITS-1:0] t_fifo_count;

    typedef struct packed {
        logic sell_cross;
        logic buy_cross;
        logic window_ready;
    } t_signal;

endpackage

### design/macs_quote_if.sv
// Handshake channel that carries one quote per item.
`timescale 1ns / 1ps

interface macs_quote_if;
    logic              valid;
    logic              ready;
    macs_pkg::t_price  bid_price;
    macs_pkg::t_price  ask_price;

    modport source (output valid, output bid_price, output ask_price, input ready);
    modport sink (input valid, input bid_price, input ask_price, output ready);
endinterface

### design/macs_signal_if.sv
// Handshake channel that carries one crossover result per item.
`timescale 1ns / 1ps

interface macs_signal_if;
    logic valid;
    logic ready;
    logic sell_cross;
    logic buy_cross;
    logic window_ready;

    modport source (output valid, output sell_cross, output buy_cross, output window_ready,
                    input ready);
    modport sink (input valid, input sell_cross, input buy_cross, input window_ready,
                  output ready);
endinterface

### design/macs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module macs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/moving_average_cross_signal_unit.sv
// Top level of the moving average crossover unit.
`timescale 1ns / 1ps

// Takes one quote per item and returns one result per item: sell_cross, buy_cross and
// window_ready. The unit sustains one item per clock cycle. Each quote passes through
// stage A, the registered read of the quote ring memory, then stage B, which registers
// the window sums and products; the comparisons after stage B are combinational. A four-entry
// result queue absorbs backpressure, and input ready drops only when that queue together
// with the items in flight would overflow. Writing average_period restarts the window;
// write it only while no item is in flight. Until max(average_period, 2) quotes have been
// stored since the last restart, all three result bits are zero, and a period of zero
// keeps them zero.
module moving_average_cross_signal_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  macs_pkg::t_period       i_cfg_wr_data,
    macs_quote_if.sink              i_quote,
    macs_signal_if.source           o_signal
);

    // Configuration and window control.
    macs_pkg::t_period     r_period;
    macs_pkg::t_ptr        r_wr_ptr;
    macs_pkg::t_count      r_count;
    macs_pkg::t_sum        r_bid_sum;
    macs_pkg::t_sum        r_ask_sum;
    macs_pkg::t_price      r_prev_bid;
    macs_pkg::t_price      r_prev_ask;

    // Stage A: quote accepted, ring read in progress.
    logic                  r_a_valid;
    macs_pkg::t_price      r_a_bid;
    macs_pkg::t_price      r_a_ask;
    macs_pkg::t_ptr        r_a_wr_ptr;
    logic                  r_a_do_sub;
    logic                  r_a_use_prev;
    logic                  r_a_en_sum;
    logic                  r_a_ready;

    // Stage B: sums and products registered.
    logic                  r_b_valid;
    logic                  r_b_ready;
    macs_pkg::t_sum        r_b_bid_sum;
    macs_pkg::t_sum        r_b_ask_sum;
    macs_pkg::t_sum        r_b_ask_p;
    macs_pkg::t_sum        r_b_bid_p;
    macs_pkg::t_sum        r_b_prev_ask_p;
    macs_pkg::t_sum        r_b_prev_bid_p;

    // Result queue.
    macs_pkg::t_signal     r_fifo [macs_pkg::FIFO_DEPTH];
    macs_pkg::t_fifo_idx   r_fifo_wr_idx;
    macs_pkg::t_fifo_idx   r_fifo_rd_idx;
    macs_pkg::t_fifo_count r_fifo_count;

    logic                  accept;
    logic                  pop;
    macs_pkg::t_cmp        period_cmp;
    macs_pkg::t_cmp        need_cmp;
    macs_pkg::t_count      n_count;
    macs_pkg::t_ptr        rd_addr;
    logic                  do_sub;
    logic                  ready_now;
    macs_pkg::t_quote      rd_data;
    macs_pkg::t_price      old_bid;
    macs_pkg::t_price      old_ask;
    macs_pkg::t_sum        n_bid_sum;
    macs_pkg::t_sum        n_ask_sum;
    macs_pkg::t_signal     result;
    macs_pkg::t_signal     head;
    macs_pkg::t_fifo_count in_flight;

    always_comb begin
        in_flight = r_fifo_count + macs_pkg::t_fifo_count'(r_a_valid)
                  + macs_pkg::t_fifo_count'(r_b_valid);
    end

    assign i_quote.ready = (in_flight < macs_pkg::t_fifo_count'(macs_pkg::FIFO_DEPTH));
    assign accept        = i_quote.valid && i_quote.ready;
    assign pop           = o_signal.valid && o_signal.ready;

    // The entry that leaves the window lies period places behind the write pointer.
    always_comb begin
        period_cmp = macs_pkg::t_cmp'(r_period);
        need_cmp   = (r_period < macs_pkg::t_period'(2)) ? macs_pkg::t_cmp'(2) : period_cmp;
        rd_addr    = r_wr_ptr - macs_pkg::t_ptr'(r_period);
        do_sub     = (r_period != '0) && (macs_pkg::t_cmp'(r_count) >= period_cmp);
        if (r_count == macs_pkg::t_count'(macs_pkg::WINDOW_DEPTH)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + macs_pkg::t_count'(1);
        end
        ready_now  = (r_period != '0) && (macs_pkg::t_cmp'(n_count) >= need_cmp);
    end

    macs_ram #(
        .WIDTH (macs_pkg::QUOTE_BITS),
        .DEPTH (macs_pkg::WINDOW_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_a_valid),
        .i_wr_addr (r_a_wr_ptr),
        .i_wr_data ({r_a_bid, r_a_ask}),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // With a period of one the leaving quote is the previous one, which may still be in
    // flight toward the ring, so it comes from the previous-quote registers instead.
    always_comb begin
        if (r_a_use_prev) begin
            old_bid = r_prev_bid;
            old_ask = r_prev_ask;
        end else begin
            old_bid = rd_data[macs_pkg::QUOTE_BITS-1:macs_pkg::PRICE_BITS];
            old_ask = rd_data[macs_pkg::PRICE_BITS-1:0];
        end
        if (r_a_do_sub) begin
            n_bid_sum = r_bid_sum - macs_pkg::t_sum'(old_bid) + macs_pkg::t_sum'(r_a_bid);
            n_ask_sum = r_ask_sum - macs_pkg::t_sum'(old_ask) + macs_pkg::t_sum'(r_a_ask);
        end else begin
            n_bid_sum = r_bid_sum + macs_pkg::t_sum'(r_a_bid);
            n_ask_sum = r_ask_sum + macs_pkg::t_sum'(r_a_ask);
        end
    end

    always_comb begin
        result.window_ready = r_b_ready;
        result.sell_cross   = r_b_ready && (r_b_ask_p < r_b_bid_sum)
                            && (r_b_bid_sum < r_b_prev_ask_p);
        result.buy_cross    = r_b_ready && (r_b_bid_p < r_b_ask_sum)
                            && (r_b_ask_sum < r_b_prev_bid_p);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= '0;
            r_wr_ptr      <= '0;
            r_count       <= '0;
            r_bid_sum     <= '0;
            r_ask_sum     <= '0;
            r_prev_bid    <= '0;
            r_prev_ask    <= '0;
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_fifo_wr_idx <= '0;
            r_fifo_rd_idx <= '0;
            r_fifo_count  <= '0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            if (i_cfg_wr_en) begin
                r_period  <= i_cfg_wr_data;
                r_wr_ptr  <= '0;
                r_count   <= '0;
                r_bid_sum <= '0;
                r_ask_sum <= '0;
            end else begin
                if (accept) begin
                    r_wr_ptr <= r_wr_ptr + macs_pkg::t_ptr'(1);
                    r_count  <= n_count;
                end
                if (r_a_valid && r_a_en_sum) begin
                    r_bid_sum <= n_bid_sum;
                    r_ask_sum <= n_ask_sum;
                end
            end
            if (r_a_valid) begin
                r_prev_bid <= r_a_bid;
                r_prev_ask <= r_a_ask;
            end
            if (r_b_valid) begin
                r_fifo_wr_idx <= r_fifo_wr_idx + macs_pkg::t_fifo_idx'(1);
            end
            if (pop) begin
                r_fifo_rd_idx <= r_fifo_rd_idx + macs_pkg::t_fifo_idx'(1);
            end
            if (r_b_valid && !pop) begin
                r_fifo_count <= r_fifo_count + macs_pkg::t_fifo_count'(1);
            end else if (!r_b_valid && pop) begin
                r_fifo_count <= r_fifo_count - macs_pkg::t_fifo_count'(1);
            end
        end
    end

    // Payload pipeline.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_bid      <= i_quote.bid_price;
            r_a_ask      <= i_quote.ask_price;
            r_a_wr_ptr   <= r_wr_ptr;
            r_a_do_sub   <= do_sub;
            r_a_use_prev <= (r_period == macs_pkg::t_period'(1));
            r_a_en_sum   <= (r_period != '0);
            r_a_ready    <= ready_now;
        end
        if (r_a_valid) begin
            r_b_ready      <= r_a_ready;
            r_b_bid_sum    <= n_bid_sum;
            r_b_ask_sum    <= n_ask_sum;
            r_b_ask_p      <= macs_pkg::t_sum'(r_a_ask) * macs_pkg::t_sum'(r_period);
            r_b_bid_p      <= macs_pkg::t_sum'(r_a_bid) * macs_pkg::t_sum'(r_period);
            r_b_prev_ask_p <= macs_pkg::t_sum'(r_prev_ask) * macs_pkg::t_sum'(r_period);
            r_b_prev_bid_p <= macs_pkg::t_sum'(r_prev_bid) * macs_pkg::t_sum'(r_period);
        end
        if (r_b_valid) begin
            r_fifo[r_fifo_wr_idx] <= result;
        end
    end

    assign head                  = r_fifo[r_fifo_rd_idx];
    assign o_signal.valid        = (r_fifo_count != '0);
    assign o_signal.sell_cross   = head.sell_cross;
    assign o_signal.buy_cross    = head.buy_cross;
    assign o_signal.window_ready = head.window_ready;

endmodule

### design/macs_checker.sv
// Port-level checker for the moving average crossover unit and its bind.
`timescale 1ns / 1ps

module macs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_wr_en,
    input macs_pkg::t_period i_cfg_wr_data,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_sell_cross,
    input logic              i_buy_cross,
    input logic              i_window_ready
);

    // Shadow of the period register as seen on the configuration port.
    macs_pkg::t_period r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    // A crossover is only reported on a full window.
    a_cross_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_sell_cross || i_buy_cross) |-> i_window_ready)
        else $error("crossover reported without a full window");

    // A period of zero keeps every result bit low.
    a_zero_period_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (r_period == '0) |-> !i_window_ready)
        else $error("window reported ready with a period of zero");

    // Reset empties the result queue.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled item keeps its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_sell_cross, i_buy_cross, i_window_ready}))
        else $error("stalled result item changed");

endmodule

bind moving_average_cross_signal_unit macs_checker u_macs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_wr_en    (i_cfg_wr_en),
    .i_cfg_wr_data  (i_cfg_wr_data),
    .i_out_valid    (o_signal.valid),
    .i_out_ready    (o_signal.ready),
    .i_sell_cross   (o_signal.sell_cross),
    .i_buy_cross    (o_signal.buy_cross),
    .i_window_ready (o_signal.window_ready)
);

### tb/moving_average_cross_signal_unit_tb.sv
// Self-checking testbench for the moving average crossover unit.
`timescale 1ns / 1ps

module moving_average_cross_signal_unit_tb;

    localparam int unsigned IDLE_LIMIT    = 3000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned HOLD_AFTER    = 700;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned RANDOM_PERIOD = 999;
    localparam int unsigned PHASES        = 12;

    typedef struct {
        macs_pkg::t_price bid;
        macs_pkg::t_price ask;
    } t_quote_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_wr_en;
    macs_pkg::t_period cfg_wr_data;

    macs_quote_if  quote_ch ();
    macs_signal_if signal_ch ();

    moving_average_cross_signal_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_quote       (quote_ch.sink),
        .o_signal      (signal_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Window state of the crossover calculation, kept alongside the block.
    macs_pkg::t_period avg_period = '0;
    macs_pkg::t_price  ring_bid [macs_pkg::WINDOW_DEPTH];
    macs_pkg::t_price  ring_ask [macs_pkg::WINDOW_DEPTH];
    int unsigned       wr_ptr = 0;
    int unsigned       stored = 0;
    logic [63:0]       bid_sum = '0;
    logic [63:0]       ask_sum = '0;
    macs_pkg::t_price  prev_bid = '0;
    macs_pkg::t_price  prev_ask = '0;

    t_quote_item       quote_backlog [$];
    macs_pkg::t_signal pending_signals [$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    logic        quote_taken = 1'b0;

    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned sink_gap = 0;
    int unsigned sink_calm = 0;
    int unsigned hold_left = 0;
    bit          long_hold_done = 1'b0;

    function automatic macs_pkg::t_signal advance_crossover_window(macs_pkg::t_price bid,
                                                                   macs_pkg::t_price ask);
        int unsigned       per;
        int unsigned       oldest;
        int unsigned       need;
        macs_pkg::t_signal res;
        per = avg_period;
        res = '0;
        if (per != 0) begin
            if (stored >= per) begin
                oldest = (wr_ptr + macs_pkg::WINDOW_DEPTH - per) % macs_pkg::WINDOW_DEPTH;
                bid_sum = bid_sum - 64'(ring_bid[oldest]);
                ask_sum = ask_sum - 64'(ring_ask[oldest]);
            end
            bid_sum = bid_sum + 64'(bid);
            ask_sum = ask_sum + 64'(ask);
        end
        ring_bid[wr_ptr] = bid;
        ring_ask[wr_ptr] = ask;
        wr_ptr = (wr_ptr + 1) % macs_pkg::WINDOW_DEPTH;
        if (stored < macs_pkg::WINDOW_DEPTH) stored++;
        need = (per < 2) ? 2 : per;
        res.window_ready = (per != 0) && (stored >= need);
        if (res.window_ready) begin
            res.sell_cross = (64'(ask) * 64'(per) < bid_sum) &&
                             (bid_sum < 64'(prev_ask) * 64'(per));
            res.buy_cross  = (64'(bid) * 64'(per) < ask_sum) &&
                             (ask_sum < 64'(prev_bid) * 64'(per));
        end
        prev_bid = bid;
        prev_ask = ask;
        return res;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 2);
        if (roll < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic macs_pkg::t_price clamp_price(longint value);
        if (value < 0) return '0;
        if (value > longint'(32'hFFFF_FFFF)) return '1;
        return macs_pkg::t_price'(value);
    endfunction

    always @(posedge i_clk) begin : crossover_monitor
        macs_pkg::t_signal want;
        macs_pkg::t_signal got;
        if (i_rst_n) begin
            if (cfg_wr_en) begin
                avg_period = cfg_wr_data;
                wr_ptr     = 0;
                stored     = 0;
                bid_sum    = '0;
                ask_sum    = '0;
            end
            if (signal_ch.valid && signal_ch.ready) begin
                got.sell_cross   = signal_ch.sell_cross;
                got.buy_cross    = signal_ch.buy_cross;
                got.window_ready = signal_ch.window_ready;
                results_seen++;
                if (pending_signals.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("result with no quote pending: sell %0b buy %0b ready %0b",
                                 got.sell_cross, got.buy_cross, got.window_ready);
                    mismatch_count++;
                end else begin
                    want = pending_signals[0];
                    pending_signals.delete(0);
                    if (got !== want) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"result %0d mismatch: sell exp %0b got %0b, ",
                                      "buy exp %0b got %0b, ready exp %0b got %0b"},
                                     results_seen, want.sell_cross, got.sell_cross,
                                     want.buy_cross, got.buy_cross,
                                     want.window_ready, got.window_ready);
                        mismatch_count++;
                    end
                end
            end
            if (quote_ch.valid && quote_ch.ready)
                pending_signals.insert(pending_signals.size(),
                    advance_crossover_window(quote_ch.bid_price, quote_ch.ask_price));
        end
        quote_taken <= i_rst_n && quote_ch.valid && quote_ch.ready;
    end

    always @(negedge i_clk) begin : quote_driver
        t_quote_item item;
        if (!i_rst_n) begin
            quote_ch.valid <= 1'b0;
        end else if (!quote_ch.valid || quote_taken) begin
            if (send_gap != 0) begin
                send_gap--;
                quote_ch.valid <= 1'b0;
            end else if (quote_backlog.size() != 0) begin
                item = quote_backlog[0];
                quote_backlog.delete(0);
                quote_ch.valid     <= 1'b1;
                quote_ch.bid_price <= item.bid;
                quote_ch.ask_price <= item.ask;
                if (send_calm != 0) begin
                    send_calm--;
                end else if ($urandom_range(0, 59) == 0) begin
                    send_calm = $urandom_range(20, 80);
                end else begin
                    send_gap = pick_gap();
                end
            end else begin
                quote_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            signal_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            signal_ch.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            // One long hold-off so the result queue fills and the input stalls.
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            signal_ch.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap--;
            signal_ch.ready <= 1'b0;
        end else begin
            signal_ch.ready <= 1'b1;
            if (sink_calm != 0) begin
                sink_calm--;
            end else if ($urandom_range(0, 59) == 0) begin
                sink_calm = $urandom_range(20, 80);
            end else begin
                sink_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || cfg_wr_en || (quote_ch.valid && quote_ch.ready) ||
            (signal_ch.valid && signal_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_quote(macs_pkg::t_price bid, macs_pkg::t_price ask);
        t_quote_item item;
        item.bid = bid;
        item.ask = ask;
        quote_backlog.insert(quote_backlog.size(), item);
    endtask

    // Wait until every queued item has gone through and its result is back.
    task automatic drain_quotes();
        do @(posedge i_clk);
        while (quote_backlog.size() != 0 || quote_ch.valid || pending_signals.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(macs_pkg::t_period value);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // A price walk with occasional jumps produces crossings; some raw noise and
    // extreme prices are mixed in.
    task automatic queue_walk(int unsigned count);
        longint      mid;
        longint      step;
        longint      spread;
        int unsigned roll;
        int unsigned level;
        level = $urandom_range(0, 3);
        if (level == 0) mid = $urandom_range(500, 5000);
        else if (level == 1) mid = longint'(32'hFFFF_FFFF) - $urandom_range(500, 5000);
        else mid = $urandom;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 84) begin
                if ($urandom_range(0, 6) == 0) begin
                    step = $urandom_range(20, 400);
                    if ($urandom_range(0, 1) == 1) step = -step;
                end else begin
                    step = longint'($urandom_range(0, 16)) - 8;
                end
                mid = longint'(clamp_price(mid + step));
                spread = longint'($urandom_range(0, 6)) - 1;
                push_quote(clamp_price(mid - spread), clamp_price(mid + spread));
            end else if (roll < 96) begin
                push_quote($urandom, $urandom);
            end else begin
                push_quote(roll[0] ? '1 : '0, roll[1] ? '1 : '0);
            end
        end
    endtask

    initial begin : stimulus
        int unsigned periods [PHASES];
        int unsigned counts  [PHASES];
        periods = '{3, 255, 0, 1, 2, 8, RANDOM_PERIOD, RANDOM_PERIOD, 16, 64, 4, 128};
        counts  = '{150, 360, 40, 80, 150, 150, 150, 150, 120, 150, 100, 50};
        quote_ch.valid      = 1'b0;
        quote_ch.bid_price  = '0;
        quote_ch.ask_price  = '0;
        signal_ch.ready     = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The period is zero out of reset, so nothing may be signaled.
        push_quote('0, '0);
        push_quote('1, '1);
        push_quote('1, '0);
        drain_quotes();

        // Period two: a sell crossing, a buy crossing, the same at full scale,
        // and equal prices that must not trigger on the strict comparison.
        write_period(8'd2);
        push_quote(32'd100, 32'd200);
        push_quote(32'd100, 32'd50);
        push_quote(32'd300, 32'd100);
        push_quote(32'd50, 32'd100);
        push_quote('0, '1);
        push_quote('1, '0);
        push_quote('0, '1);
        push_quote(32'd100, 32'd100);
        push_quote(32'd100, 32'd100);
        drain_quotes();

        // Period one still needs two stored quotes before the window is ready.
        write_period(8'd1);
        push_quote(32'd5, 32'd5);
        push_quote(32'd10, 32'd3);
        push_quote(32'd2, 32'd8);
        push_quote(32'd7, 32'd7);
        drain_quotes();

        for (int unsigned p = 0; p < PHASES; p++) begin
            if (periods[p] == RANDOM_PERIOD)
                write_period(macs_pkg::t_period'($urandom_range(1, 255)));
            else
                write_period(macs_pkg::t_period'(periods[p]));
            queue_walk(counts[p]);
            drain_quotes();
        end

        if (mismatch_count == 0 && pending_signals.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
